FILE: hdl/nll_pkg.sv
package nll_pkg;

   // Scan phase of the literal
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ZERO   = 3'd1,
      PH_DEC    = 3'd2,
      PH_OCT    = 3'd3,
      PH_HEX    = 3'd4,
      PH_DOT    = 3'd5,
      PH_SUFFIX = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_I32  = 3'd0,
      KIND_I64  = 3'd1,
      KIND_I16  = 3'd2,
      KIND_BYTE = 3'd3,
      KIND_ERR  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_DEC   = 3'd1,
      ERR_BAD_OCT   = 3'd2,
      ERR_BAD_HEX   = 3'd3,
      ERR_TOO_LARGE = 3'd4,
      ERR_BAD_SFX   = 3'd5,
      ERR_TRAIL_LF  = 3'd6,
      ERR_REAL      = 3'd7
   } err_type;

   // Lexer state carried from byte to byte
   typedef struct packed {
      phase_type   phase;
      logic [63:0] acc;
      logic        digit_seen;
      logic [7:0]  sfx_first;
      logic [1:0]  sfx_count;
   } state_type;

   // One result transaction
   typedef struct packed {
      kind_type    kind;
      err_type     err;
      logic [63:0] value;
      logic [1:0]  replay;
   } result_type;

   localparam state_type StateReset = '{
      phase:      PH_IDLE,
      acc:        64'd0,
      digit_seen: 1'b0,
      sfx_first:  8'd0,
      sfx_count:  2'd0
   };

   // Overflow limits for each radix
   localparam logic [63:0] DecLimit = 64'h1999_9999_9999_9999;
   localparam logic [63:0] OctLimit = 64'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] HexLimit = 64'h0FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] I16Max   = 64'd65535;
   localparam logic [63:0] ByteMax  = 64'd255;

   // Character codes
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChSeven = 8'h37;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChDot   = 8'h2E;
   localparam logic [7:0] ChUpA   = 8'h41;
   localparam logic [7:0] ChUpF   = 8'h46;
   localparam logic [7:0] ChUpZ   = 8'h5A;
   localparam logic [7:0] ChLoA   = 8'h61;
   localparam logic [7:0] ChLoF   = 8'h66;
   localparam logic [7:0] ChLoZ   = 8'h7A;
   localparam logic [7:0] ChUpL   = 8'h4C;
   localparam logic [7:0] ChLoL   = 8'h6C;
   localparam logic [7:0] ChUpH   = 8'h48;
   localparam logic [7:0] ChLoH   = 8'h68;
   localparam logic [7:0] ChUpX   = 8'h58;
   localparam logic [7:0] ChLoX   = 8'h78;

endpackage

FILE: hdl/nll_core.sv
module nll_core (
   input  nll_pkg::state_type  state,
   input  logic [7:0]          ch,
   input  logic                letterform,
   input  logic                present,
   output nll_pkg::state_type  state_next,
   output logic                fire,
   output nll_pkg::result_type result
);

   logic        is_digit;
   logic        is_octal;
   logic        is_alnum;
   logic [4:0]  hex_val;
   logic        is_hex;
   logic [64:0] dec_sum;
   logic [63:0] oct_next;
   logic [63:0] hex_next;
   logic [1:0]  end_replay;
   nll_pkg::result_type cls_res;
   nll_pkg::result_type fin_res;

   // Build a result transaction
   function automatic nll_pkg::result_type make_res(nll_pkg::kind_type k, nll_pkg::err_type e,
                                                    logic [63:0] v, logic [1:0] r);
      nll_pkg::result_type res;
      res.kind   = k;
      res.err    = e;
      res.value  = (k == nll_pkg::KIND_ERR) ? 64'd0 : v;
      res.replay = r;
      return res;
   endfunction

   // Classify the suffix against the accumulated value
   function automatic nll_pkg::result_type classify(nll_pkg::state_type s, logic [1:0] r);
      nll_pkg::result_type res;
      res = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_BAD_SFX, 64'd0, r);
      if (s.sfx_count == 2'd0) begin
         if (s.acc[63:32] != 32'd0)
            res = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_TOO_LARGE, 64'd0, r);
         else
            res = make_res(nll_pkg::KIND_I32, nll_pkg::ERR_NONE, s.acc, r);
      end else if (s.sfx_count == 2'd1) begin
         if (s.sfx_first == nll_pkg::ChLoL || s.sfx_first == nll_pkg::ChUpL) begin
            res = make_res(nll_pkg::KIND_I64, nll_pkg::ERR_NONE, s.acc, r);
         end else if (s.sfx_first == nll_pkg::ChLoH || s.sfx_first == nll_pkg::ChUpH) begin
            if (s.acc > nll_pkg::I16Max)
               res = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_TOO_LARGE, 64'd0, r);
            else
               res = make_res(nll_pkg::KIND_I16, nll_pkg::ERR_NONE, s.acc, r);
         end else if (s.sfx_first == nll_pkg::ChLoX || s.sfx_first == nll_pkg::ChUpX) begin
            if (s.acc > nll_pkg::ByteMax)
               res = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_TOO_LARGE, 64'd0, r);
            else
               res = make_res(nll_pkg::KIND_BYTE, nll_pkg::ERR_NONE, s.acc, r);
         end
      end
      return res;
   endfunction

   // Character classes of the present byte
   assign is_digit = present && ch >= nll_pkg::ChZero && ch <= nll_pkg::ChNine;
   assign is_octal = present && ch >= nll_pkg::ChZero && ch <= nll_pkg::ChSeven;
   assign is_alnum = present && ((ch >= nll_pkg::ChZero && ch <= nll_pkg::ChNine) ||
                                 (ch >= nll_pkg::ChUpA && ch <= nll_pkg::ChUpZ) ||
                                 (ch >= nll_pkg::ChLoA && ch <= nll_pkg::ChLoZ));

   always_comb begin
      if (ch >= nll_pkg::ChZero && ch <= nll_pkg::ChNine)
         hex_val = {1'b0, ch[3:0]};
      else if ((ch >= nll_pkg::ChLoA && ch <= nll_pkg::ChLoF) ||
               (ch >= nll_pkg::ChUpA && ch <= nll_pkg::ChUpF))
         hex_val = 5'(ch[2:0] + 3'd1) + 5'd8;
      else
         hex_val = 5'd16;
   end
   assign is_hex = present && !hex_val[4];

   // Digit accumulation: acc*10 + d with carry, octal and hex shifts
   assign dec_sum  = {1'b0, state.acc[60:0], 3'b000} + {1'b0, state.acc[62:0], 1'b0}
                   + {61'd0, ch[3:0]};
   assign oct_next = {state.acc[60:0], ch[2:0]};
   assign hex_next = {state.acc[59:0], hex_val[3:0]};

   // End of literal: trailing letter or suffix classification
   assign end_replay = present ? 2'd1 : 2'd0;
   assign cls_res    = classify(state, end_replay);
   assign fin_res    = (present && letterform)
                     ? make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_TRAIL_LF, 64'd0, 2'd0)
                     : cls_res;

   // Next state and result for one byte
   always_comb begin
      state_next = state;
      fire       = 1'b0;
      result     = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_NONE, 64'd0, 2'd0);
      unique case (state.phase) inside
         nll_pkg::PH_IDLE: begin
            if (is_digit) begin
               state_next.acc        = {60'd0, ch[3:0]};
               state_next.digit_seen = 1'b1;
               state_next.phase      = (ch == nll_pkg::ChZero) ? nll_pkg::PH_ZERO
                                                               : nll_pkg::PH_DEC;
            end
         end
         nll_pkg::PH_ZERO, nll_pkg::PH_OCT: begin
            if (state.phase == nll_pkg::PH_ZERO && present &&
                (ch == nll_pkg::ChLoX || ch == nll_pkg::ChUpX)) begin
               state_next.phase      = nll_pkg::PH_HEX;
               state_next.digit_seen = 1'b0;
               state_next.acc        = 64'd0;
            end else if (is_octal) begin
               if (state.acc > nll_pkg::OctLimit) begin
                  fire   = 1'b1;
                  result = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_BAD_OCT, 64'd0, 2'd1);
               end else begin
                  state_next.acc   = oct_next;
                  state_next.phase = nll_pkg::PH_OCT;
               end
            end else if (present && ch == nll_pkg::ChDot) begin
               state_next.phase = nll_pkg::PH_DOT;
            end else if (is_alnum) begin
               state_next.phase     = nll_pkg::PH_SUFFIX;
               state_next.sfx_first = ch;
               state_next.sfx_count = 2'd1;
            end else begin
               fire   = 1'b1;
               result = fin_res;
            end
         end
         nll_pkg::PH_DEC: begin
            if (is_digit) begin
               if (state.acc > nll_pkg::DecLimit || dec_sum[64]) begin
                  fire   = 1'b1;
                  result = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_BAD_DEC, 64'd0, 2'd1);
               end else begin
                  state_next.acc = dec_sum[63:0];
               end
            end else if (present && ch == nll_pkg::ChDot) begin
               state_next.phase = nll_pkg::PH_DOT;
            end else if (is_alnum) begin
               state_next.phase     = nll_pkg::PH_SUFFIX;
               state_next.sfx_first = ch;
               state_next.sfx_count = 2'd1;
            end else begin
               fire   = 1'b1;
               result = fin_res;
            end
         end
         nll_pkg::PH_HEX: begin
            if (!state.digit_seen) begin
               if (is_hex) begin
                  state_next.acc        = {60'd0, hex_val[3:0]};
                  state_next.digit_seen = 1'b1;
               end else begin
                  // "0x" alone: byte zero unless a letter follows
                  fire = 1'b1;
                  if (present && letterform)
                     result = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_TRAIL_LF, 64'd0, 2'd0);
                  else
                     result = make_res(nll_pkg::KIND_BYTE, nll_pkg::ERR_NONE, 64'd0,
                                       end_replay);
               end
            end else if (is_hex) begin
               if (state.acc > nll_pkg::HexLimit) begin
                  fire   = 1'b1;
                  result = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_BAD_HEX, 64'd0, 2'd0);
               end else begin
                  state_next.acc = hex_next;
               end
            end else if (is_alnum) begin
               state_next.phase     = nll_pkg::PH_SUFFIX;
               state_next.sfx_first = ch;
               state_next.sfx_count = 2'd1;
            end else begin
               fire   = 1'b1;
               result = fin_res;
            end
         end
         nll_pkg::PH_DOT: begin
            fire = 1'b1;
            if (present && ch == nll_pkg::ChDot)
               result = classify(state, 2'd2);
            else
               result = make_res(nll_pkg::KIND_ERR, nll_pkg::ERR_REAL, 64'd0, end_replay);
         end
         nll_pkg::PH_SUFFIX: begin
            if (is_alnum) begin
               if (state.sfx_count != 2'd2)
                  state_next.sfx_count = state.sfx_count + 2'd1;
            end else begin
               fire   = 1'b1;
               result = fin_res;
            end
         end
         default: begin
            state_next = nll_pkg::StateReset;
         end
      endcase
      // Every result returns the lexer to idle
      if (fire)
         state_next = nll_pkg::StateReset;
   end

endmodule

FILE: hdl/numeric_literal_lexer.sv
// Numeric literal lexer: one source byte per transaction, one result per literal.
// Throughput: one byte per cycle while rsp is not stalled, no gaps between literals.
// A result reaches rsp once the byte ending the literal has passed the input register,
// one pass of scan logic and the result register; a stalled rsp can hold it in between.
// Reset (synchronous, active high) empties both registers and returns the scan to idle.
module numeric_literal_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] letterform
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] value, [65:64] replay_count, [71:66] zero
   output logic [5:0]  rsp_tuser    // [2:0] kind, [5:3] error_code
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_ch_ff, in_ch_in;
   logic                in_lf_ff, in_lf_in;
   logic                in_eot_ff, in_eot_in;
   nll_pkg::state_type  state_ff, state_in;
   nll_pkg::state_type  state_next;
   logic                out_valid_ff, out_valid_in;
   nll_pkg::result_type out_ff, out_in;
   nll_pkg::result_type result;
   logic                fire;
   logic                out_free;
   logic                advance;

   // Scan logic for the registered byte
   nll_core u_core (
      .state      (state_ff),
      .ch         (in_ch_ff),
      .letterform (in_lf_ff),
      .present    (!in_eot_ff),
      .state_next (state_next),
      .fire       (fire),
      .result     (result)
   );

   // Advance the held byte when the result slot can take its outcome
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      in_lf_in    = in_lf_ff;
      in_eot_in   = in_eot_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_ch_in    = req_tdata;
         in_lf_in    = req_tuser;
         in_eot_in   = req_tlast;
      end
   end

   // Update scan state and the result register
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         state_in     = state_next;
         out_valid_in = fire;
         if (fire)
            out_in = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= nll_pkg::StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      in_ch_ff  <= in_ch_in;
      in_lf_ff  <= in_lf_in;
      in_eot_ff <= in_eot_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.replay, out_ff.value};
   assign rsp_tuser  = {out_ff.err, out_ff.kind};

endmodule
